// ----- rtl/ipvrr_pkg.sv -----
// ----------------------------------------------------------------------------
// ipvrr_pkg
// Shared types and constants of the insertion/promotion vector RRIP block:
// field widths, operation and register codes, controller/datapath buses and
// the random-number LFSR step.
// ----------------------------------------------------------------------------
package ipvrr_pkg;

    // Widths of the word fields.
    localparam int SET_W    = 11;
    localparam int WAY_W    = 4;
    localparam int VEC_W    = 8;
    localparam int VEC_ENTS = 4;
    localparam int LFSR_W   = 16;

    // Operation codes carried in tuser.
    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_DEMAND   = 1'b0;
    localparam logic CFG_PREFETCH = 1'b1;

    localparam logic [VEC_W-1:0]  VEC_RESET = 8'd128;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [3:0]        DIV_LAST  = 4'(LFSR_W - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;  // write one reset row during the clearing pass
        logic load;      // capture an accepted word
        logic addr_rd;   // reduce the set index and read the row
        logic row_proc;  // update or age the row and write it back
        logic div_step;  // one step of the remainder unit
        logic pick;      // select the victim and load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // clearing pass writes its last row
        logic op_victim;  // captured word is a victim request
        logic div_last;   // remainder unit does its last step
    } t_status;

    // One step of the Galois LFSR: shift right, fold the taps in on a one.
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] t;
        t = s >> 1;
        if (s[0]) begin
            t = t ^ LFSR_TAPS;
        end
        return t;
    endfunction

endpackage

// ----- rtl/ipv_rrip_replacement.sv -----
// ----------------------------------------------------------------------------
// ipv_rrip_replacement
// Per-set RRIP replacement policy driven by a demand and a prefetch
// insertion/promotion vector, with an LFSR-based pick among the oldest ways.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake             Payload
// s (in)    in   i_s_tvalid/o_s_tready tuser: op; tdata: set_index, way,
//                                      is_prefetch, hit
// m (out)   out  o_m_tvalid/i_m_tready tdata: victim_way
// cfg       in   i_cfg_we              i_cfg_idx, i_cfg_wdata (no read-back)
//
// For an update word, from accept to the next accept, the set index
// is reduced modulo SETS, the row is read from the single-port row memory and
// written back. A victim request does the same row read, aging and
// write-back, then runs the bit-serial remainder unit, which reduces
// the LFSR value modulo the candidate count step by step, then the pick.
// After reset the block runs a clearing pass over all SETS rows that sets every
// way to LEVELS-1; the input is not ready meanwhile, configuration writes are
// taken. A finished victim waits in the output register while the next word
// is accepted; a second victim stalls in its pick step until the first one
// is taken.
//
module ipv_rrip_replacement #(
    parameter int SETS   = 2048,
    parameter int WAYS   = 16,
    parameter int LEVELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // set_index[10:0], way[14:11], is_prefetch[15], hit[16]
    input  logic        i_s_tuser,   // op[0]: 0 = find victim, 1 = update
    // Result words.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // victim_way[3:0]
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);
    import ipvrr_pkg::*;

    t_cmd             cmd;
    t_status          status;
    logic [WAY_W-1:0] victim_way;

    // The controller owns the handshakes; the datapath owns the memory and data registers.
    ipvrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ipvrr_dp #(
        .SETS   (SETS),
        .WAYS   (WAYS),
        .LEVELS (LEVELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_s_tuser),
        .i_set_index   (i_s_tdata[10:0]),
        .i_way         (i_s_tdata[14:11]),
        .i_is_prefetch (i_s_tdata[15]),
        .i_hit         (i_s_tdata[16]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_victim_way  (victim_way)
    );

    // Result word: victim way in the low nibble, zeros above.
    assign o_m_tdata = {4'b0000, victim_way};

endmodule

// ----- rtl/ipvrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ipvrr_ctrl
// Controller of the RRIP block: sequences the clearing pass, the row
// read-modify-write, the remainder steps and the output register.
// ----------------------------------------------------------------------------
module ipvrr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  ipvrr_pkg::t_status i_status,
    output ipvrr_pkg::t_cmd    o_cmd
);
    import ipvrr_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADDR,
        ST_ROW,
        ST_DIV,
        ST_PICK
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear_wr = (r_state == ST_CLEAR);
        o_cmd.load     = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.addr_rd  = (r_state == ST_ADDR);
        o_cmd.row_proc = (r_state == ST_ROW);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.pick     = (r_state == ST_PICK) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            // A new victim replaces a word that is taken in the same cycle.
            if (o_cmd.pick) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    if (i_status.clr_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_state <= ST_ROW;
                end
                ST_ROW: begin
                    r_state <= i_status.op_victim ? ST_DIV : ST_IDLE;
                end
                ST_DIV: begin
                    if (i_status.div_last) begin
                        r_state <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // One word at a time: after an accept the input side closes.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted twice in a row");

    // A result only appears at the end of a victim request.
    a_valid_from_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_PICK))
        else $error("output valid without a victim pick");

endmodule

// ----- rtl/ipvrr_dp.sv -----
// ----------------------------------------------------------------------------
// ipvrr_dp
// Datapath of the RRIP block: vector registers, the RRPV row memory, set
// index reduction, update and aging logic, LFSR, a bit-serial remainder unit
// and the victim select.
// ----------------------------------------------------------------------------
module ipvrr_dp #(
    parameter int SETS   = 2048,
    parameter int WAYS   = 16,
    parameter int LEVELS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ipvrr_pkg::t_cmd                 i_cmd,
    output ipvrr_pkg::t_status              o_status,
    input  logic                            i_op,
    input  logic [ipvrr_pkg::SET_W-1:0]     i_set_index,
    input  logic [ipvrr_pkg::WAY_W-1:0]     i_way,
    input  logic                            i_is_prefetch,
    input  logic                            i_hit,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [ipvrr_pkg::VEC_W-1:0]     i_cfg_wdata,
    output logic [ipvrr_pkg::WAY_W-1:0]     o_victim_way
);
    import ipvrr_pkg::*;

    localparam int AW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LW    = $clog2(LEVELS);
    localparam int WW    = $clog2(WAYS);
    localparam int CW    = $clog2(WAYS + 1);
    localparam int SH    = SET_W + AW;
    localparam int MW    = SET_W + 2;
    localparam int QW    = SET_W + MW;
    localparam int RW    = SET_W + AW + 1;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / SETS);
    localparam logic [LW-1:0] TOP   = LW'(LEVELS - 1);
    localparam logic [RW-1:0] SETS_R = RW'(SETS);

    typedef logic [WAYS-1:0][LW-1:0] t_row;

    // Configuration.
    logic [VEC_W-1:0] r_dvec;
    logic [VEC_W-1:0] r_pvec;

    // Captured word.
    logic             r_op;
    logic [SET_W-1:0] r_set;
    logic [SET_W-1:0] r_q;
    logic [WAY_W-1:0] r_way;
    logic             r_pf;
    logic             r_hit;

    // Row memory and its read register.
    t_row             r_mem [SETS];
    t_row             r_rd_row;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_clr_idx;

    // Victim search state.
    logic [LFSR_W-1:0] r_lfsr;
    logic [WAYS-1:0]   r_mask;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_rem;
    logic [3:0]        r_div_cnt;
    logic [WAY_W-1:0]  r_victim;

    // Combinational signals.
    logic [QW-1:0]     q_prod;
    logic [RW-1:0]     qs;
    logic [RW-1:0]     rem_raw;
    logic [RW-1:0]     rem_fix;
    logic [AW-1:0]     rd_addr;
    logic [WW-1:0]     way_idx;
    logic              way_ok;
    logic [LW-1:0]     ent_idx;
    logic [VEC_W-1:0]  vec;
    logic [1:0]        ent_raw;
    logic [LW-1:0]     new_v;
    t_row              upd_row;
    logic [LEVELS-2:0] lvl_any;
    logic [LW-1:0]     add;
    t_row              aged;
    logic [WAYS-1:0]   top_mask;
    logic [CW-1:0]     top_cnt;
    logic [CW:0]       div_t;
    logic [CW-1:0]     div_n;
    logic [WAYS-1:0]   low_m;
    logic [CW-1:0]     rank;
    logic [WAY_W-1:0]  chosen;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_row              mem_wdata;

    // Set index modulo SETS: reciprocal estimate at accept, one correction later.
    assign q_prod  = QW'(i_set_index) * QW'(RECIP);
    assign qs      = RW'(r_q) * SETS_R;
    assign rem_raw = RW'(r_set) - qs;
    assign rem_fix = (rem_raw >= SETS_R) ? rem_raw - SETS_R : rem_raw;
    assign rd_addr = AW'(rem_fix);

    // Update: new RRPV from the selected vector.
    always_comb begin
        way_idx = WW'(r_way);
        way_ok  = (int'(r_way) < WAYS);
        ent_idx = r_hit ? r_rd_row[way_idx] : TOP;
        vec     = r_pf ? r_pvec : r_dvec;
        ent_raw = 2'b00;
        if (int'(ent_idx) < VEC_ENTS) begin
            ent_raw = 2'(vec >> {ent_idx, 1'b0});
        end
        if (int'(ent_raw) > LEVELS - 1) begin
            new_v = TOP;
        end else begin
            new_v = LW'(ent_raw);
        end
        upd_row          = r_rd_row;
        upd_row[way_idx] = new_v;
    end

    // Aging: the shortfall of the maximum is the number of empty upper levels.
    always_comb begin
        for (int l = 0; l < LEVELS - 1; l++) begin
            lvl_any[l] = 1'b0;
            for (int w = 0; w < WAYS; w++) begin
                if (r_rd_row[w] >= LW'(l + 1)) begin
                    lvl_any[l] = 1'b1;
                end
            end
        end
        add = LW'(LEVELS - 1 - $countones(lvl_any));
        for (int w = 0; w < WAYS; w++) begin
            aged[w]     = r_rd_row[w] + add;
            top_mask[w] = (aged[w] == TOP);
        end
        top_cnt = CW'($countones(top_mask));
        if (top_cnt == '0) begin
            top_cnt = CW'(1);
        end
    end

    // Restoring remainder step, one LFSR bit per cycle from the top.
    always_comb begin
        div_t = {r_rem, r_lfsr[DIV_LAST - r_div_cnt]};
        if (div_t >= {1'b0, r_count}) begin
            div_n = CW'(div_t - {1'b0, r_count});
        end else begin
            div_n = CW'(div_t);
        end
    end

    // Victim: the candidate whose rank among the top ways equals the remainder.
    always_comb begin
        chosen = '0;
        low_m  = '0;
        rank   = '0;
        for (int w = 0; w < WAYS; w++) begin
            low_m = {WAYS{1'b1}} >> (WAYS - w);
            rank  = CW'($countones(r_mask & low_m));
            if (r_mask[w] && (rank == r_rem)) begin
                chosen = WAY_W'(w);
            end
        end
    end

    // Memory write port: clearing pass or row write-back.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = upd_row;
        if (i_cmd.clear_wr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = {WAYS{TOP}};
        end else if (i_cmd.row_proc) begin
            if (r_op == OP_VICTIM) begin
                mem_we    = 1'b1;
                mem_wdata = aged;
            end else begin
                mem_we = way_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.addr_rd) begin
            r_rd_row <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvec    <= VEC_RESET;
            r_pvec    <= VEC_RESET;
            r_lfsr    <= LFSR_SEED;
            r_clr_idx <= '0;
            r_div_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEMAND:   r_dvec <= i_cfg_wdata;
                    CFG_PREFETCH: r_pvec <= i_cfg_wdata;
                    default:      r_dvec <= r_dvec;
                endcase
            end
            if (i_cmd.clear_wr) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (i_cmd.row_proc && (r_op == OP_VICTIM)) begin
                r_lfsr    <= lfsr_next(r_lfsr);
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 4'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_set <= i_set_index;
            r_q   <= SET_W'(q_prod >> SH);
            r_way <= i_way;
            r_pf  <= i_is_prefetch;
            r_hit <= i_hit;
        end
        if (i_cmd.addr_rd) begin
            r_addr <= rd_addr;
        end
        if (i_cmd.row_proc) begin
            r_mask  <= top_mask;
            r_count <= top_cnt;
            r_rem   <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_n;
        end
        if (i_cmd.pick) begin
            r_victim <= chosen;
        end
    end

    assign o_status.clr_last  = (r_clr_idx == AW'(SETS - 1));
    assign o_status.op_victim = (r_op == OP_VICTIM);
    assign o_status.div_last  = (r_div_cnt == DIV_LAST);
    assign o_victim_way       = r_victim;

    // The partial remainder stays below the candidate count.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step || i_cmd.pick) |-> (r_rem < r_count))
        else $error("remainder not below candidate count");

    // After aging at least one way sits at the top level.
    a_mask_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick |-> (r_mask != '0))
        else $error("no victim candidate in the set");

endmodule
